FILE: hw/rtl/aptc_pkg.sv
// ----------------------------------------------------------------------------
// Altitude thrust control package
// Types, fixed-point constants, the control store and a saturation helper
// shared by the altitude thrust control core and its testbench.
// ----------------------------------------------------------------------------
package aptc_pkg;

   // Fixed-point constants (Q16.16 unless noted)
   localparam logic signed [31:0] GRAVITY_Q16 = 32'sd642908;   // 9.81 m/s^2
   localparam logic signed [19:0] SUM_LIMIT   = 20'sd262144;   // 4.0
   localparam logic        [16:0] COS_FLOOR   = 17'd66;        // about 0.001
   localparam logic        [16:0] COS_ONE     = 17'd65536;     // 1.0
   localparam logic        [24:0] OUT_MAX     = 25'h1FF_FFFF;
   localparam logic        [26:0] QUO_SAT     = 27'h400_0000;  // quotient overflow marker
   localparam logic        [4:0]  DIV_BITS_M1 = 5'd25;         // quotient bits less one

   localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
   localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

   // Configuration register indexes
   localparam logic [2:0] CSR_GAIN_POSITION    = 3'd0;
   localparam logic [2:0] CSR_GAIN_VELOCITY    = 3'd1;
   localparam logic [2:0] CSR_GAIN_INTEGRAL    = 3'd2;
   localparam logic [2:0] CSR_ASCENT_LIMIT     = 3'd3;
   localparam logic [2:0] CSR_DESCENT_LIMIT    = 3'd4;
   localparam logic [2:0] CSR_VEHICLE_MASS     = 3'd5;
   localparam logic [2:0] CSR_MOTOR_THRUST_MIN = 3'd6;
   localparam logic [2:0] CSR_MOTOR_THRUST_MAX = 3'd7;

   typedef logic [4:0] step_type;

   // Micro-operations of the datapath
   typedef enum logic [4:0] {
      OP_VCMD,    // clamp commanded climb to the speed limits
      OP_HERR,    // height error, saturated
      OP_VERR,    // climb error, saturated
      OP_EMUL,    // height error times time step
      OP_ISUM,    // update the clamped error sum
      OP_PMUL,    // position gain product
      OP_PACC,    // start the acceleration sum with feed-forward
      OP_VMUL,    // velocity gain product
      OP_VACC,    // add velocity term
      OP_IMUL,    // integral gain product
      OP_IACC,    // add integral term
      OP_GRAV,    // gravity minus acceleration
      OP_QXSQ,    // qx squared
      OP_QYSQ,    // add qy squared
      OP_COS,     // tilt cosine with floor
      OP_MMUL,    // mass times net acceleration
      OP_CHECK,   // set up the divider or take the quick result
      OP_DIV,     // one quotient bit
      OP_OUT      // clamp and hand over the result
   } op_type;

   typedef enum logic [1:0] {
      COND_NONE,  // fall through
      COND_SKIP,  // jump when the quotient needs no division
      COND_LOOP   // jump while quotient bits remain
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   localparam step_type STEP_DIV = 5'd17;
   localparam step_type STEP_OUT = 5'd18;

   // Control store
   function automatic ctrl_word_type ctrl_rom(input step_type s);
      ctrl_word_type w;
      w = '{op: OP_OUT, cond: COND_NONE, target: '0};
      unique case (s)
         5'd0:  w = '{op: OP_VCMD,  cond: COND_NONE, target: '0};
         5'd1:  w = '{op: OP_HERR,  cond: COND_NONE, target: '0};
         5'd2:  w = '{op: OP_VERR,  cond: COND_NONE, target: '0};
         5'd3:  w = '{op: OP_EMUL,  cond: COND_NONE, target: '0};
         5'd4:  w = '{op: OP_ISUM,  cond: COND_NONE, target: '0};
         5'd5:  w = '{op: OP_PMUL,  cond: COND_NONE, target: '0};
         5'd6:  w = '{op: OP_PACC,  cond: COND_NONE, target: '0};
         5'd7:  w = '{op: OP_VMUL,  cond: COND_NONE, target: '0};
         5'd8:  w = '{op: OP_VACC,  cond: COND_NONE, target: '0};
         5'd9:  w = '{op: OP_IMUL,  cond: COND_NONE, target: '0};
         5'd10: w = '{op: OP_IACC,  cond: COND_NONE, target: '0};
         5'd11: w = '{op: OP_GRAV,  cond: COND_NONE, target: '0};
         5'd12: w = '{op: OP_QXSQ,  cond: COND_NONE, target: '0};
         5'd13: w = '{op: OP_QYSQ,  cond: COND_NONE, target: '0};
         5'd14: w = '{op: OP_COS,   cond: COND_NONE, target: '0};
         5'd15: w = '{op: OP_MMUL,  cond: COND_NONE, target: '0};
         5'd16: w = '{op: OP_CHECK, cond: COND_SKIP, target: STEP_OUT};
         5'd17: w = '{op: OP_DIV,   cond: COND_LOOP, target: STEP_DIV};
         5'd18: w = '{op: OP_OUT,   cond: COND_NONE, target: '0};
         default: w = '{op: OP_OUT, cond: COND_NONE, target: '0};
      endcase
      return w;
   endfunction

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = $signed(v[31:0]);
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/altitude_pid_thrust_control_core.sv
// ----------------------------------------------------------------------------
// Altitude thrust control core
// PID altitude loop with tilt compensation, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// One request transaction carries a control tick (commanded and measured down
// position and velocity, feed-forward acceleration, time step, quaternion x/y)
// and yields one response transaction with the collective thrust in Q16.16.
// A tick runs the program from acceptance to the next acceptance; when the
// quotient is known at once (mass times net acceleration <= 0, or quotient
// beyond any thrust limit), the division steps are skipped. The restoring
// divider yields one quotient bit per cycle over 26 bits; the rest of the
// program is one step per cycle through a single shared 32x18 multiplier.
// A finished result waits in the response register while the next request
// is taken; the program stalls on its last step only if the previous
// response has not yet been taken. Configuration writes take effect at once
// and must only be issued while the core is idle.
// ----------------------------------------------------------------------------
module altitude_pid_thrust_control_core
   import aptc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // target_height[31:0], target_climb[63:32], measured_height[95:64],
   // measured_climb[127:96], feedforward_accel[159:128], time_step[176:160],
   // att_qx[192:177], att_qy[208:193], zero pad[215:209]
   input  logic [215:0] req_tdata,
   // response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // collective_thrust[24:0], zero pad[31:25]
   output logic [31:0]  rsp_tdata,
   // configuration writes
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [22:0]  csr_wdata
);

   // Configuration registers
   logic [15:0] gain_position_ff, gain_velocity_ff, gain_integral_ff, vehicle_mass_ff;
   logic [20:0] ascent_limit_ff, descent_limit_ff;
   logic [22:0] motor_thrust_min_ff, motor_thrust_max_ff;

   // Latched request fields
   logic signed [31:0] target_height_ff, target_climb_ff;
   logic signed [31:0] measured_height_ff, measured_climb_ff, feedforward_accel_ff;
   logic        [16:0] time_step_ff;
   logic signed [15:0] att_qx_ff, att_qy_ff;

   // Sequencer
   logic          busy_ff, busy_in;
   step_type      step_ff, step_in;
   ctrl_word_type cw;
   logic          jump;
   logic          stall;

   // Datapath registers
   logic signed [31:0] vcmd_ff, vcmd_in;
   logic signed [31:0] herr_ff, herr_in;
   logic signed [31:0] verr_ff, verr_in;
   logic signed [48:0] prod_ff, prod_in;
   logic signed [34:0] acc_ff, acc_in;
   logic signed [19:0] sum_ff, sum_in;
   logic signed [31:0] net_ff, net_in;
   logic        [16:0] cos_ff, cos_in;
   logic        [16:0] rem_ff, rem_in;
   logic        [25:0] dvd_ff, dvd_in;
   logic        [26:0] quo_ff, quo_in;
   logic        [4:0]  cnt_ff, cnt_in;
   logic        [24:0] thrust_ff, thrust_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Shared multiplier
   logic signed [31:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [49:0] mul_p;

   // Step intermediates
   logic signed [32:0] climb_w, asc_neg_w, desc_w, diff_w;
   logic signed [48:0] sum_w, grav_w, cos_w, div_lim;
   logic signed [31:0] term_w;
   logic        [17:0] cand_w;
   logic        [25:0] lo_w, hi_w;
   logic        [26:0] clamp_w;
   logic               div_skip;

   assign cw    = ctrl_rom(step_ff);
   assign stall = busy_ff && (cw.op == OP_OUT) && rsp_valid_ff && !rsp_tready;

   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, thrust_ff};

   // Quick quotient: non-positive numerator or quotient beyond 26 bits
   assign div_lim  = $signed({14'b0, cos_ff, 18'b0});
   assign div_skip = (prod_ff <= 49'sd0) || (prod_ff >= div_lim);

   always_comb begin
      unique case (cw.cond)
         COND_SKIP: jump = div_skip;
         COND_LOOP: jump = (cnt_ff != 5'd0);
         default:   jump = 1'b0;
      endcase
   end

   // Pick multiplier operands for the current step
   always_comb begin
      mul_a = herr_ff;
      mul_b = $signed({1'b0, time_step_ff});
      unique case (cw.op)
         OP_PMUL: begin
            mul_a = herr_ff;
            mul_b = $signed({2'b0, gain_position_ff});
         end
         OP_VMUL: begin
            mul_a = verr_ff;
            mul_b = $signed({2'b0, gain_velocity_ff});
         end
         OP_IMUL: begin
            mul_a = 32'(sum_ff);
            mul_b = $signed({2'b0, gain_integral_ff});
         end
         OP_QXSQ: begin
            mul_a = 32'(att_qx_ff);
            mul_b = 18'(att_qx_ff);
         end
         OP_QYSQ: begin
            mul_a = 32'(att_qy_ff);
            mul_b = 18'(att_qy_ff);
         end
         OP_MMUL: begin
            mul_a = net_ff;
            mul_b = $signed({2'b0, vehicle_mass_ff});
         end
         default: begin
            mul_a = herr_ff;
            mul_b = $signed({1'b0, time_step_ff});
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Step intermediates shared by the datapath below
   assign climb_w   = 33'(target_climb_ff);
   assign asc_neg_w = -$signed({12'b0, ascent_limit_ff});
   assign desc_w    = $signed({12'b0, descent_limit_ff});
   assign term_w    = sat32(prod_ff >>> 8);
   assign sum_w     = 49'(sum_ff) + (prod_ff >>> 16);
   assign grav_w    = 49'(GRAVITY_Q16) - 49'(sat32(49'(acc_ff)));
   assign cos_w     = $signed({32'b0, COS_ONE}) - (prod_ff >>> 13);
   assign cand_w    = {rem_ff, dvd_ff[25]};
   assign lo_w      = {1'b0, motor_thrust_min_ff, 2'b0} + {3'b0, motor_thrust_min_ff};
   assign hi_w      = {1'b0, motor_thrust_max_ff, 2'b0} + {3'b0, motor_thrust_max_ff};

   always_comb begin
      unique case (cw.op)
         OP_HERR: diff_w = 33'(target_height_ff) - 33'(measured_height_ff);
         default: diff_w = 33'(vcmd_ff) - 33'(measured_climb_ff);
      endcase
   end

   // Clamp the quotient to the scaled motor limits, the lower bound checked first
   always_comb begin
      if (quo_ff < {1'b0, lo_w}) begin
         clamp_w = {1'b0, lo_w};
      end else if (quo_ff > {1'b0, hi_w}) begin
         clamp_w = {1'b0, hi_w};
      end else begin
         clamp_w = quo_ff;
      end
   end

   // Datapath
   always_comb begin
      vcmd_in   = vcmd_ff;
      herr_in   = herr_ff;
      verr_in   = verr_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      sum_in    = sum_ff;
      net_in    = net_ff;
      cos_in    = cos_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      thrust_in = thrust_ff;
      if (busy_ff && !stall) begin
         unique case (cw.op)
            OP_VCMD: begin
               if (climb_w < asc_neg_w) begin
                  vcmd_in = 32'(asc_neg_w);
               end else if (climb_w > desc_w) begin
                  vcmd_in = 32'(desc_w);
               end else begin
                  vcmd_in = target_climb_ff;
               end
            end
            OP_HERR: herr_in = sat32(49'(diff_w));
            OP_VERR: verr_in = sat32(49'(diff_w));
            OP_EMUL, OP_PMUL, OP_VMUL, OP_IMUL, OP_QXSQ, OP_MMUL: begin
               prod_in = mul_p[48:0];
            end
            OP_QYSQ: prod_in = prod_ff + mul_p[48:0];
            OP_ISUM: begin
               if (sum_w > 49'(SUM_LIMIT)) begin
                  sum_in = SUM_LIMIT;
               end else if (sum_w < -49'(SUM_LIMIT)) begin
                  sum_in = -SUM_LIMIT;
               end else begin
                  sum_in = sum_w[19:0];
               end
            end
            OP_PACC: acc_in = 35'(feedforward_accel_ff) + 35'(term_w);
            OP_VACC, OP_IACC: acc_in = acc_ff + 35'(term_w);
            OP_GRAV: net_in = sat32(grav_w);
            OP_COS: begin
               // floor the cosine so strong tilt cannot blow up the thrust
               if (cos_w < $signed({32'b0, COS_FLOOR})) begin
                  cos_in = COS_FLOOR;
               end else begin
                  cos_in = cos_w[16:0];
               end
            end
            OP_CHECK: begin
               quo_in = '0;
               if (prod_ff <= 49'sd0) begin
                  quo_in = '0;
               end else if (prod_ff >= div_lim) begin
                  quo_in = QUO_SAT;
               end else begin
                  rem_in = prod_ff[34:18];
                  dvd_in = {prod_ff[17:0], 8'b0};
                  cnt_in = DIV_BITS_M1;
               end
            end
            OP_DIV: begin
               if (cand_w >= {1'b0, cos_ff}) begin
                  rem_in = 17'(cand_w - {1'b0, cos_ff});
                  quo_in = {quo_ff[25:0], 1'b1};
               end else begin
                  rem_in = cand_w[16:0];
                  quo_in = {quo_ff[25:0], 1'b0};
               end
               dvd_in = {dvd_ff[24:0], 1'b0};
               cnt_in = cnt_ff - 5'd1;
            end
            OP_OUT: begin
               if (clamp_w > {2'b0, OUT_MAX}) begin
                  thrust_in = OUT_MAX;
               end else begin
                  thrust_in = clamp_w[24:0];
               end
            end
            default: begin
               prod_in = prod_ff;
            end
         endcase
      end
   end

   // Sequencer and response handshake
   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (!busy_ff) begin
         if (req_tvalid) begin
            busy_in = 1'b1;
            step_in = '0;
         end
      end else if (!stall) begin
         if (cw.op == OP_OUT) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end else if (jump) begin
            step_in = cw.target;
         end else begin
            step_in = step_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
   end

   // Payload: latch the request transaction, advance the datapath
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         target_height_ff     <= $signed(req_tdata[31:0]);
         target_climb_ff      <= $signed(req_tdata[63:32]);
         measured_height_ff   <= $signed(req_tdata[95:64]);
         measured_climb_ff    <= $signed(req_tdata[127:96]);
         feedforward_accel_ff <= $signed(req_tdata[159:128]);
         time_step_ff         <= req_tdata[176:160];
         att_qx_ff            <= $signed(req_tdata[192:177]);
         att_qy_ff            <= $signed(req_tdata[208:193]);
      end
      vcmd_ff   <= vcmd_in;
      herr_ff   <= herr_in;
      verr_ff   <= verr_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      net_ff    <= net_in;
      cos_ff    <= cos_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      thrust_ff <= thrust_in;
   end

   // Configuration registers: unknown indexes cannot occur with a 3-bit index
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_position_ff    <= '0;
         gain_velocity_ff    <= '0;
         gain_integral_ff    <= '0;
         ascent_limit_ff     <= 21'd1310720;
         descent_limit_ff    <= 21'd1310720;
         vehicle_mass_ff     <= 16'd256;
         motor_thrust_min_ff <= '0;
         motor_thrust_max_ff <= 23'd6553600;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GAIN_POSITION:    gain_position_ff    <= csr_wdata[15:0];
            CSR_GAIN_VELOCITY:    gain_velocity_ff    <= csr_wdata[15:0];
            CSR_GAIN_INTEGRAL:    gain_integral_ff    <= csr_wdata[15:0];
            CSR_ASCENT_LIMIT:     ascent_limit_ff     <= csr_wdata[20:0];
            CSR_DESCENT_LIMIT:    descent_limit_ff    <= csr_wdata[20:0];
            CSR_VEHICLE_MASS:     vehicle_mass_ff     <= csr_wdata[15:0];
            CSR_MOTOR_THRUST_MIN: motor_thrust_min_ff <= csr_wdata;
            CSR_MOTOR_THRUST_MAX: motor_thrust_max_ff <= csr_wdata;
            default:              gain_position_ff    <= gain_position_ff;
         endcase
      end
   end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Altitude thrust control core testbench
// Streams control ticks into the core and checks every collective thrust
// transaction against a fixed-point predictor (own error sum and register
// copy) or a directed row's typed-in thrust. A short directed table covers
// the reset settings, field extremes, zero mass, crossed motor limits and
// output saturation. Random phases with fresh settings follow, with idling
// on both streams, one long receiver hold-off and one mid-phase sender drain.
// ----------------------------------------------------------------------------
module tb_top
   import aptc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int LONG_HOLD    = 400;     // receiver hold-off that fills the core
   localparam int TICK_CYCLES  = 45;      // slowest tick, divider included
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_TICKS  = 82;
   localparam int S32_MIN      = 32'sh8000_0000;
   localparam int S32_MAX      = 32'sh7FFF_FFFF;

   // One control tick as carried by a request transaction
   typedef struct {
      logic signed [31:0] target_height;
      logic signed [31:0] target_climb;
      logic signed [31:0] measured_height;
      logic signed [31:0] measured_climb;
      logic signed [31:0] feedforward_accel;
      logic        [16:0] time_step;
      logic signed [15:0] att_qx;
      logic signed [15:0] att_qy;
   } tick_type;

   // Register file as seen by the controller
   typedef struct {
      logic [15:0] gain_position;
      logic [15:0] gain_velocity;
      logic [15:0] gain_integral;
      logic [20:0] ascent_limit;
      logic [20:0] descent_limit;
      logic [15:0] vehicle_mass;
      logic [22:0] motor_thrust_min;
      logic [22:0] motor_thrust_max;
   } pid_settings_type;

   // Directed table entry: settings set, tick, and an optional typed-in thrust
   typedef struct {
      int          phase;
      tick_type    tick;
      bit          typed;
      logic [24:0] thrust;
   } dir_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [215:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_addr;
   logic [22:0]  csr_wdata;

   // Predictor state: register copy and the clamped height error sum
   pid_settings_type ctl;
   longint           error_sum = 0;

   logic [24:0]   thrust_queue[$];    // expected thrust, oldest first
   dir_row_type   dir_rows[$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            hold_requests = 0;  // bumped by the sender to ask for a long hold-off
   bit            req_idle_on = 1'b1;
   bit            rsp_idle_on = 1'b1;

   altitude_pid_thrust_control_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog: give up on a hung core
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------
   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Run one tick: advance the error sum, return the clamped collective thrust
   function automatic logic [24:0] predict_thrust(input tick_type t);
      longint vcmd, herr, verr, sum, pterm, vterm, iterm, acc, net_acc, cosv, thr, lo, hi;
      vcmd = longint'(t.target_climb);
      if (vcmd < -longint'(ctl.ascent_limit)) vcmd = -longint'(ctl.ascent_limit);
      else if (vcmd > longint'(ctl.descent_limit)) vcmd = longint'(ctl.descent_limit);
      herr = clip32(longint'(t.target_height) - longint'(t.measured_height));
      verr = clip32(vcmd - longint'(t.measured_climb));

      // Integrate with a floor shift, then hold the sum within +-4.0
      sum = error_sum + ((herr * longint'(t.time_step)) >>> 16);
      if (sum < -longint'(SUM_LIMIT)) sum = -longint'(SUM_LIMIT);
      else if (sum > longint'(SUM_LIMIT)) sum = longint'(SUM_LIMIT);
      error_sum = sum;

      pterm = clip32((longint'(ctl.gain_position) * herr) >>> 8);
      vterm = clip32((longint'(ctl.gain_velocity) * verr) >>> 8);
      iterm = clip32((longint'(ctl.gain_integral) * sum) >>> 8);
      acc = clip32(pterm + vterm + iterm + longint'(t.feedforward_accel));
      net_acc = clip32(longint'(GRAVITY_Q16) - acc);

      // Tilt cosine in Q16.16, floored near 0.001
      cosv = longint'(COS_ONE)
             - ((longint'(t.att_qx) * longint'(t.att_qx)
                 + longint'(t.att_qy) * longint'(t.att_qy)) >>> 13);
      if (cosv < longint'(COS_FLOOR)) cosv = longint'(COS_FLOOR);

      thr = (longint'(ctl.vehicle_mass) * net_acc * 256) / cosv;

      // Lower bound is checked first; with crossed limits, thrust at or above it gets the upper bound
      lo = 5 * longint'(ctl.motor_thrust_min);
      hi = 5 * longint'(ctl.motor_thrust_max);
      if (thr < lo) thr = lo;
      else if (thr > hi) thr = hi;
      if (thr > longint'(OUT_MAX)) thr = longint'(OUT_MAX);
      if (thr < 0) thr = 0;
      return thr[24:0];
   endfunction

   // ---------------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------------
   function automatic int rand_span(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return 0;
      if (roll < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic int unsigned corner_value(input int unsigned high, input int width);
      int unsigned mask;
      mask = (1 << width) - 1;
      case ($urandom_range(0, 3))
         0: return 0;
         1: return high;
         2: return mask;
         default: return $urandom() & mask;
      endcase
   endfunction

   function automatic pid_settings_type make_settings(
      input int unsigned gp, input int unsigned gv, input int unsigned gi,
      input int unsigned asc, input int unsigned dsc, input int unsigned mass,
      input int unsigned tmin, input int unsigned tmax);
      pid_settings_type s;
      s.gain_position    = 16'(gp);
      s.gain_velocity    = 16'(gv);
      s.gain_integral    = 16'(gi);
      s.ascent_limit     = 21'(asc);
      s.descent_limit    = 21'(dsc);
      s.vehicle_mass     = 16'(mass);
      s.motor_thrust_min = 23'(tmin);
      s.motor_thrust_max = 23'(tmax);
      return s;
   endfunction

   // Flyable settings, or corners of every register's range
   function automatic pid_settings_type draw_settings(input bit corners);
      if (corners) begin
         return make_settings(corner_value(65535, 16), corner_value(65535, 16),
                              corner_value(65535, 16), corner_value(1310720, 21),
                              corner_value(1310720, 21), corner_value(65535, 16),
                              corner_value(6553600, 23), corner_value(6553600, 23));
      end
      return make_settings($urandom_range(0, 1024), $urandom_range(0, 1024),
                           $urandom_range(0, 512), $urandom_range(327680, 1310720),
                           $urandom_range(327680, 1310720), $urandom_range(128, 1024),
                           $urandom_range(0, 65536), $urandom_range(3276800, 6553600));
   endfunction

   // Mostly plausible flight ticks around a phase-wide height offset; the
   // offset keeps the error sum drifting into its clamp. The rest is noise.
   function automatic tick_type draw_tick(input int bias);
      tick_type t;
      if ($urandom_range(0, 4) == 0) begin
         t.target_height     = $urandom();
         t.target_climb      = $urandom();
         t.measured_height   = $urandom();
         t.measured_climb    = $urandom();
         t.feedforward_accel = $urandom();
         t.time_step         = 17'($urandom_range(0, 131071));
         t.att_qx            = 16'($urandom());
         t.att_qy            = 16'($urandom());
      end else begin
         t.target_height     = rand_span(6553600);
         t.measured_height   = t.target_height + bias + rand_span(65536);
         t.target_climb      = rand_span(1638400);
         t.measured_climb    = t.target_climb + rand_span(131072);
         t.feedforward_accel = rand_span(327680);
         t.time_step         = 17'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 131071)
                                                                : $urandom_range(0, 6554));
         t.att_qx            = 16'(rand_span(9000));
         t.att_qy            = 16'(rand_span(9000));
      end
      return t;
   endfunction

   // ---------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------
   task automatic add_row(input int phase, input int th, input int tc, input int mh,
                          input int mc, input int ff, input int ts, input int qx,
                          input int qy, input bit typed, input int thrust);
      dir_row_type r;
      r.phase                  = phase;
      r.tick.target_height     = th;
      r.tick.target_climb      = tc;
      r.tick.measured_height   = mh;
      r.tick.measured_climb    = mc;
      r.tick.feedforward_accel = ff;
      r.tick.time_step         = 17'(ts);
      r.tick.att_qx            = 16'(qx);
      r.tick.att_qy            = 16'(qy);
      r.typed                  = typed;
      r.thrust                 = 25'(thrust);
      dir_rows.push_back(r);
   endtask

   // Offer one tick, hold it until accepted, then book the expected thrust.
   // Leaves tvalid high so that a back-to-back tick is offered without a gap.
   task automatic offer_tick(input tick_type t, input bit typed,
                             input logic [24:0] typed_val);
      int gap;
      logic [24:0] want;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, t.att_qy, t.att_qx, t.time_step, t.feedforward_accel,
                     t.measured_climb, t.measured_height, t.target_climb,
                     t.target_height};
      do @(posedge clock); while (!req_tready);
      // The predictor must run even for typed rows to keep the error sum in step
      want = predict_thrust(t);
      if (typed) want = typed_val;
      thrust_queue.push_back(want);
   endtask

   // Hold until every booked thrust has come back
   task automatic drain_thrust();
      while (thrust_queue.size() != 0) @(posedge clock);
   endtask

   task automatic put_csr(input logic [2:0] idx, input logic [22:0] value);
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write every register; only call while the core is idle
   task automatic load_settings(input pid_settings_type s);
      csr_we <= 1'b1;
      put_csr(CSR_GAIN_POSITION, 23'(s.gain_position));
      put_csr(CSR_GAIN_VELOCITY, 23'(s.gain_velocity));
      put_csr(CSR_GAIN_INTEGRAL, 23'(s.gain_integral));
      put_csr(CSR_ASCENT_LIMIT, 23'(s.ascent_limit));
      put_csr(CSR_DESCENT_LIMIT, 23'(s.descent_limit));
      put_csr(CSR_VEHICLE_MASS, 23'(s.vehicle_mass));
      put_csr(CSR_MOTOR_THRUST_MIN, s.motor_thrust_min);
      put_csr(CSR_MOTOR_THRUST_MAX, s.motor_thrust_max);
      csr_we <= 1'b0;
      ctl = s;
   endtask

   initial begin : stimulus
      pid_settings_type dir_cfg[5];
      int cur_phase;
      int bias;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;

      // Settings sets of the directed part: reset values, all-out gains with
      // one-sided speed limits, zero mass, crossed motor limits, and motor
      // limits whose five-fold bound lies beyond the output range
      dir_cfg[0] = make_settings(0, 0, 0, 1310720, 1310720, 256, 0, 6553600);
      dir_cfg[1] = make_settings(65535, 65535, 65535, 0, 2097151, 65535, 0, 8388607);
      dir_cfg[2] = make_settings(0, 0, 0, 1310720, 1310720, 0, 0, 6553600);
      dir_cfg[3] = make_settings(0, 0, 0, 1310720, 1310720, 256, 4000000, 1000);
      dir_cfg[4] = make_settings(0, 0, 0, 1310720, 1310720, 256, 8388607, 8388607);
      ctl = dir_cfg[0];

      // Reset settings: zero gains and unit mass, so a level tick yields exactly
      // g minus the feed-forward term, held to the motor limits
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 642908);
      add_row(0, 0, 0, 0, 0, 642908, 65536, 0, 0, 1'b1, 0);
      add_row(0, 0, 0, 0, 0, S32_MIN, 65536, 0, 0, 1'b1, 32768000);
      add_row(0, 0, 0, 0, 0, S32_MAX, 65536, 0, 0, 1'b1, 0);
      // error extremes and an oversized time step drive the sum into its clamp
      add_row(0, S32_MAX, S32_MAX, S32_MIN, S32_MIN, 0, 131071, 0, 0, 1'b1, 642908);
      add_row(0, S32_MIN, S32_MIN, S32_MAX, S32_MAX, 0, 65536, 0, 0, 1'b1, 642908);
      // tilt: cosine floor at both quaternion extremes, and a 60 degree bank
      add_row(0, 0, 0, 0, 0, 0, 6554, -32768, -32768, 1'b1, 32768000);
      add_row(0, 0, 0, 0, 0, 0, 6554, 16384, 0, 1'b1, 1285816);
      add_row(0, 0, 0, 0, 0, 0, 6554, 32767, 32767, 1'b1, 32768000);
      // full gains: climb clamps, gain product saturation, tiny steps
      add_row(1, 65536, S32_MIN, 0, 0, 0, 65536, 0, 0, 1'b0, 0);
      add_row(1, 0, S32_MAX, 65536, 0, 0, 6554, 4096, -4096, 1'b0, 0);
      add_row(1, -1, -65536, 0, 65536, -100000, 1, -1, 1, 1'b0, 0);
      add_row(1, 32767, 0, -32768, 0, 0, 0, 0, 0, 1'b0, 0);
      add_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 0);
      add_row(1, S32_MAX, 0, S32_MIN, 0, 0, 131071, 0, 0, 1'b0, 0);
      // zero mass gives no thrust at all
      add_row(2, 0, 0, 0, 0, 0, 6554, 0, 0, 1'b1, 0);
      add_row(2, 0, 0, 0, 0, -1000000, 6554, -32768, 0, 1'b1, 0);
      // crossed limits: the lower bound wins
      add_row(3, 0, 0, 0, 0, 0, 6554, 0, 0, 1'b1, 20000000);
      add_row(3, 0, 0, 0, 0, S32_MAX, 6554, 0, 0, 1'b1, 20000000);
      // lower bound above the 25-bit range saturates the output
      add_row(4, 0, 0, 0, 0, 0, 6554, 0, 0, 1'b1, 33554431);
      add_row(4, 0, 0, 0, 0, 0, 6554, -32768, -32768, 1'b1, 33554431);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      cur_phase = 0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].phase != cur_phase) begin
            req_tvalid <= 1'b0;
            drain_thrust();
            load_settings(dir_cfg[dir_rows[i].phase]);
            cur_phase = dir_rows[i].phase;
         end
         offer_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].thrust);
      end

      // Random phases: every third uses register corners; idling is switched
      // off on one side or the other in some phases
      for (int p = 0; p < RAND_PHASES; p++) begin
         req_tvalid <= 1'b0;
         drain_thrust();
         load_settings(draw_settings(p % 3 == 2));
         bias        = rand_span(327680);
         req_idle_on = (p % 4 != 1);
         rsp_idle_on = (p % 4 != 3);
         for (int n = 0; n < PHASE_TICKS; n++) begin
            // long receiver hold-off while the sender keeps pushing
            if (p == 2 && n == 30) begin
               hold_requests++;
               req_idle_on = 1'b0;
            end
            if (p == 2 && n == 50) req_idle_on = 1'b1;
            // sender pauses until the core has handed everything back
            if (p == 5 && n == 40) begin
               req_tvalid <= 1'b0;
               drain_thrust();
            end
            offer_tick(draw_tick(bias), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      drain_thrust();
      // catch any stray transaction after the last expected one
      repeat (TICK_CYCLES + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Receiver side: random stalls, plus the long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin : rsp_side
      int stall_left;
      int holds_taken;
      stall_left  = 0;
      holds_taken = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) stall_left--;
         if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            stall_left  = LONG_HOLD;
         end else if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = pick_gap();
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   // ---------------------------------------------------------------------------
   // Checker: compare each response transaction with the oldest booked thrust
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_thrust
      logic [24:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (thrust_queue.size() == 0) begin
            $error("collective_thrust: no transaction expected, actual %0d",
                   rsp_tdata[24:0]);
            mismatch_count++;
         end else begin
            want = thrust_queue.pop_front();
            if (rsp_tdata[24:0] !== want) begin
               $error("collective_thrust mismatch: expected %0d, actual %0d",
                      want, rsp_tdata[24:0]);
               mismatch_count++;
            end
         end
      end
   end

endmodule

FILE: files.f
hw/rtl/aptc_pkg.sv
hw/rtl/altitude_pid_thrust_control_core.sv
dv/tb_top.sv
